>>> hdl/sem_pkg.sv
// Shared types, constants and helpers for the Sobel edge magnitude core.
// Used by every module under hdl/; depends on nothing else.
package sem_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int PIXEL_W           = 8;
    localparam int CFG_ADDR_W        = 1;
    localparam int CFG_DATA_W        = 11;
    localparam int ROW_W             = 11;
    localparam int SUM_W             = 10;   // 1+2+1 weighted sum of three pixels

    localparam logic [CFG_DATA_W-1:0] HEIGHT_LIMIT = CFG_DATA_W'(1024);
    localparam logic [PIXEL_W-1:0]    PIXEL_MAX    = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic               req_type;
        logic [PIXEL_W-1:0] pixel;
    } pix_beat_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] magnitude;
        logic               end_of_row;
        logic               end_of_frame;
    } mag_beat_t;

    // per-item control that travels with the window shift
    typedef struct packed {
        logic emit;
        logic lft_en;
        logic rgt_en;
        logic eor;
        logic eof;
    } win_ctrl_t;

    typedef struct packed {
        logic      row_ge1;
        logic      row_ge2;
        logic      in_image;
        win_ctrl_t ctrl;
    } pos_info_t;

    function automatic logic [SUM_W-1:0] wsum(input logic [PIXEL_W-1:0] a,
                                              input logic [PIXEL_W-1:0] b,
                                              input logic [PIXEL_W-1:0] c);
        wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // |p - n| saturated to the pixel range
    function automatic logic [PIXEL_W-1:0] abs_sat(input logic [SUM_W-1:0] p,
                                                   input logic [SUM_W-1:0] n);
        logic [SUM_W-1:0] d;
        d = (p >= n) ? (p - n) : (n - p);
        abs_sat = (d > SUM_W'(PIXEL_MAX)) ? PIXEL_MAX : d[PIXEL_W-1:0];
    endfunction

endpackage

>>> hdl/sobel_edge_magnitude_core.sv
// Sobel 3x3 edge magnitude (L1) core: top level.
// Instantiates sem_pos, sem_line_buf and sem_kernel; uses sem_pkg.
//
// Takes one raster pixel (or drain beat) per clock while pix_ready is high
// and returns min(sat(|gx|) + sat(|gy|), 255) for each frame pixel, zero
// padding outside the frame. Sustained rate is one beat per clock unless the
// output stalls; an emitting beat's window is registered on acceptance and
// its result enters the output register once it is free. The result for
// a centre pixel leaves after frame_width + 1 further input beats, so each
// frame must be followed by frame_width + 1 drain beats. The line store is
// read at the next beat's column, so its registered output is ready when
// that beat is taken. Register writes rewind the frame position and must
// be made while the core is idle; no clearing pass is needed after reset.
module sobel_edge_magnitude_core #(
    parameter  int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sem_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  sem_pkg::pix_beat_t               pix_data,
    output logic                             mag_valid,
    input  logic                             mag_ready,
    output sem_pkg::mag_beat_t               mag_data
);

    logic                                accept;
    logic                                take;
    logic [COL_W-1:0]                    col;
    logic [COL_W-1:0]                    col_next;
    sem_pkg::pos_info_t                  info;
    logic [2*sem_pkg::PIXEL_W-1:0]       lb_rd_data;
    logic [sem_pkg::PIXEL_W-1:0]         top;
    logic [sem_pkg::PIXEL_W-1:0]         mid;
    logic [sem_pkg::PIXEL_W-1:0]         px;

    assign pix_ready = take;
    assign accept    = pix_valid && take;

    sem_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .col       (col),
        .col_next  (col_next),
        .info      (info)
    );

    // rows above the frame read as zero whatever the store holds
    assign top = info.row_ge2 ? lb_rd_data[2*sem_pkg::PIXEL_W-1:sem_pkg::PIXEL_W] : '0;
    assign mid = info.row_ge1 ? lb_rd_data[sem_pkg::PIXEL_W-1:0] : '0;
    assign px  = (info.in_image && (pix_data.req_type == sem_pkg::REQ_PIXEL))
                 ? pix_data.pixel : '0;

    sem_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (col),
        .wr_data ({mid, px}),
        .rd_addr (col_next),
        .rd_data (lb_rd_data)
    );

    sem_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .top       (top),
        .mid       (mid),
        .px        (px),
        .ctrl      (info.ctrl),
        .take      (take),
        .mag_valid (mag_valid),
        .mag_ready (mag_ready),
        .mag_data  (mag_data)
    );

endmodule

>>> hdl/sem_line_buf.sv
// Two-row line store: one entry per column holds {upper, middle} pixels.
// Registered read with write-to-read bypass. Uses sem_pkg.
module sem_line_buf #(
    parameter  int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH,
    localparam int ADDR_W    = $clog2(MAX_WIDTH),
    localparam int DATA_W    = 2 * sem_pkg::PIXEL_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [MAX_WIDTH];
    logic [DATA_W-1:0] ram_q_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic              byp_reg;
    logic              byp_next;

    assign byp_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        ram_q_reg    <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : ram_q_reg;

endmodule

>>> hdl/sem_pos.sv
// Configuration registers and raster position (column/row) tracking.
// Produces the per-item window control. Uses sem_pkg.
module sem_pos #(
    parameter  int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int FW_W      = ($clog2(MAX_WIDTH + 1) > sem_pkg::CFG_DATA_W)
                               ? $clog2(MAX_WIDTH + 1) : sem_pkg::CFG_DATA_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sem_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [sem_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                accept,
    output logic [COL_W-1:0]                    col,
    output logic [COL_W-1:0]                    col_next,
    output sem_pkg::pos_info_t                  info
);

    localparam int                RESET_W_INT = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam logic [FW_W-1:0]   RESET_W     = FW_W'(RESET_W_INT);
    localparam logic [FW_W-1:0]   MAX_W       = FW_W'(MAX_WIDTH);

    logic [FW_W-1:0]                 frame_w_reg, frame_w_next;
    logic [sem_pkg::CFG_DATA_W-1:0]  frame_h_reg, frame_h_next;
    logic [COL_W-1:0]                col_reg;
    logic [sem_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [FW_W-1:0]                 wdata_ext;
    logic [FW_W-1:0]                 col_ext;
    logic [sem_pkg::ROW_W-1:0]       h_plus1;
    logic                            last_col;
    logic                            wrap;
    logic                            col0;

    assign wdata_ext = FW_W'(cfg_wdata);
    assign col_ext   = FW_W'(col_reg);
    assign h_plus1   = sem_pkg::ROW_W'(frame_h_reg) + sem_pkg::ROW_W'(1);
    assign last_col  = col_ext >= (frame_w_reg - FW_W'(1));
    assign wrap      = row_reg >= h_plus1;
    assign col0      = (col_reg == '0);

    // out-of-range sizes are clamped when written
    always_comb
    begin
        frame_w_next = frame_w_reg;
        frame_h_next = frame_h_reg;
        if (cfg_we)
        begin
            case (sem_pkg::cfg_reg_t'(cfg_addr))
                sem_pkg::CFG_FRAME_WIDTH:
                begin
                    if (cfg_wdata == '0)
                        frame_w_next = FW_W'(1);
                    else if (wdata_ext > MAX_W)
                        frame_w_next = MAX_W;
                    else
                        frame_w_next = wdata_ext;
                end
                sem_pkg::CFG_FRAME_HEIGHT:
                begin
                    if (cfg_wdata == '0)
                        frame_h_next = sem_pkg::CFG_DATA_W'(1);
                    else if (cfg_wdata > sem_pkg::HEIGHT_LIMIT)
                        frame_h_next = sem_pkg::HEIGHT_LIMIT;
                    else
                        frame_h_next = cfg_wdata;
                end
                default:
                begin
                    frame_w_next = frame_w_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (wrap)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + sem_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= RESET_W;
            frame_h_reg <= sem_pkg::HEIGHT_LIMIT;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            frame_w_reg <= frame_w_next;
            frame_h_reg <= frame_h_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // column 0 closes the previous row: right side is padding
    always_comb
    begin
        info.row_ge1     = (row_reg != '0);
        info.row_ge2     = (row_reg >= sem_pkg::ROW_W'(2));
        info.in_image    = (row_reg < sem_pkg::ROW_W'(frame_h_reg));
        info.ctrl.emit   = info.row_ge2 || ((row_reg == sem_pkg::ROW_W'(1)) && !col0);
        info.ctrl.rgt_en = !col0;
        info.ctrl.lft_en = col0 ? (frame_w_reg != FW_W'(1)) : (col_ext >= FW_W'(2));
        info.ctrl.eor    = col0;
        info.ctrl.eof    = col0 && (row_reg == h_plus1);
    end

    assign col = col_reg;

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_ext < frame_w_reg)
        else $error("column position beyond frame width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_plus1)
        else $error("row position beyond drain row");

    a_cfg_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (col_reg == '0) && (row_reg == '0))
        else $error("register write did not rewind frame position");

endmodule

>>> hdl/sem_kernel.sv
// 3x3 window, Sobel X/Y response, L1 magnitude and output register.
// Uses sem_pkg.
module sem_kernel (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [sem_pkg::PIXEL_W-1:0]     top,
    input  logic [sem_pkg::PIXEL_W-1:0]     mid,
    input  logic [sem_pkg::PIXEL_W-1:0]     px,
    input  sem_pkg::win_ctrl_t              ctrl,
    output logic                            take,
    output logic                            mag_valid,
    input  logic                            mag_ready,
    output sem_pkg::mag_beat_t              mag_data
);

    // win_reg[column][row], column 2 newest, row 0 top
    logic [2:0][2:0][sem_pkg::PIXEL_W-1:0] win_reg, win_next;
    sem_pkg::win_ctrl_t                    s1_ctrl_reg;
    logic                                  s1_valid_reg, s1_valid_next;
    logic                                  out_valid_reg, out_valid_next;
    sem_pkg::mag_beat_t                    out_beat_reg;
    sem_pkg::mag_beat_t                    result;
    logic                                  out_free;
    logic                                  advance;
    logic [2:0][sem_pkg::PIXEL_W-1:0]      lft, cen, rgt;
    logic [sem_pkg::PIXEL_W-1:0]           ax, ay;
    logic [sem_pkg::PIXEL_W:0]             sum;

    assign out_free = !out_valid_reg || mag_ready;
    assign advance  = s1_valid_reg && out_free;
    assign take     = !s1_valid_reg || out_free;

    always_comb
    begin
        win_next = win_reg;
        if (accept)
        begin
            win_next[0]    = win_reg[1];
            win_next[1]    = win_reg[2];
            win_next[2][0] = top;
            win_next[2][1] = mid;
            win_next[2][2] = px;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = ctrl.emit;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (mag_ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        lft = s1_ctrl_reg.lft_en ? win_reg[0] : '0;
        cen = win_reg[1];
        rgt = s1_ctrl_reg.rgt_en ? win_reg[2] : '0;
        ax  = sem_pkg::abs_sat(sem_pkg::wsum(rgt[0], rgt[1], rgt[2]),
                               sem_pkg::wsum(lft[0], lft[1], lft[2]));
        ay  = sem_pkg::abs_sat(sem_pkg::wsum(lft[2], cen[2], rgt[2]),
                               sem_pkg::wsum(lft[0], cen[0], rgt[0]));
        sum = {1'b0, ax} + {1'b0, ay};
        result.magnitude    = sum[sem_pkg::PIXEL_W] ? sem_pkg::PIXEL_MAX
                                                    : sum[sem_pkg::PIXEL_W-1:0];
        result.end_of_row   = s1_ctrl_reg.eor;
        result.end_of_frame = s1_ctrl_reg.eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_ctrl_reg <= ctrl;
        if (advance)
            out_beat_reg <= result;
    end

    assign mag_valid = out_valid_reg;
    assign mag_data  = out_beat_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> take)
        else $error("window shifted while a computed item was stalled");

    a_eof_is_eor: assert property (@(posedge clk) disable iff (!rst_n)
        mag_valid |-> (!mag_data.end_of_frame || mag_data.end_of_row))
        else $error("end of frame without end of row");

    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> mag_valid)
        else $error("computed item lost on the way to the output register");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for sobel_edge_magnitude_core: raster frames with drain beats,
// register sweeps and back-pressure, checked against a built-in Sobel L1 predictor.
// Depends on sem_pkg and the core under hdl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW        = sem_pkg::DEFAULT_MAX_WIDTH;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYC  = 8;
    localparam int RANDOM_BEATS = 300;

    typedef enum int {
        FILL_RANDOM,
        FILL_WHITE,
        FILL_BLACK,
        FILL_CHECKER,
        FILL_STRIPES
    } fill_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sem_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [sem_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           pix_valid;
    logic                           pix_ready;
    sem_pkg::pix_beat_t             pix_data;
    logic                           mag_valid;
    logic                           mag_ready;
    sem_pkg::mag_beat_t             mag_data;

    sobel_edge_magnitude_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .mag_valid (mag_valid),
        .mag_ready (mag_ready),
        .mag_data  (mag_data)
    );

    // predictor state
    logic [sem_pkg::CFG_DATA_W-1:0] cfg_width;
    logic [sem_pkg::CFG_DATA_W-1:0] cfg_height;
    logic [sem_pkg::PIXEL_W-1:0]    prev2_line [MAXW];
    logic [sem_pkg::PIXEL_W-1:0]    prev1_line [MAXW];
    logic [sem_pkg::PIXEL_W-1:0]    taps [3][3];     // [column][row], column 2 newest
    int                             pos_col;
    int                             pos_row;

    sem_pkg::mag_beat_t expected_mag [$];

    int  err_count;
    int  beats_sent;
    int  results_seen;
    int  reg_writes;
    bit  src_idles;
    bit  sink_idles;
    bit  src_held;
    int  hold_off_len;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int frame_cols();
        if (cfg_width == '0)
            return 1;
        if (int'(cfg_width) > MAXW)
            return MAXW;
        return int'(cfg_width);
    endfunction

    function automatic int frame_rows();
        if (cfg_height == '0)
            return 1;
        if (cfg_height > sem_pkg::HEIGHT_LIMIT)
            return int'(sem_pkg::HEIGHT_LIMIT);
        return int'(cfg_height);
    endfunction

    function automatic int sat_abs(input int v);
        int a;
        a = (v < 0) ? -v : v;
        return (a > 255) ? 255 : a;
    endfunction

    // advance the predictor by one input beat; emits says whether a result comes out
    function automatic void sobel_predict(input sem_pkg::pix_beat_t b, output bit emits,
                                          output sem_pkg::mag_beat_t res);
        int w, h, c, r, mc, mr, gx, gy, s, k;
        logic [sem_pkg::PIXEL_W-1:0] px, top, mid;
        logic [sem_pkg::PIXEL_W-1:0] lft [3];
        logic [sem_pkg::PIXEL_W-1:0] cen [3];
        logic [sem_pkg::PIXEL_W-1:0] rgt [3];
        w = frame_cols();
        h = frame_rows();
        c = pos_col;
        r = pos_row;
        px  = (b.req_type == sem_pkg::REQ_PIXEL && r < h) ? b.pixel : '0;
        top = (r >= 2) ? prev2_line[c] : '0;
        mid = (r >= 1) ? prev1_line[c] : '0;
        emits = (r >= 2) || (r == 1 && c >= 1);
        prev2_line[c] = mid;
        prev1_line[c] = px;
        for (k = 0; k < 3; k++)
        begin
            taps[0][k] = taps[1][k];
            taps[1][k] = taps[2][k];
        end
        taps[2][0] = top;
        taps[2][1] = mid;
        taps[2][2] = px;
        if (c == 0)
        begin
            // centre is the last column of the row above, right side is padding
            mc = w - 1;
            mr = (r >= 2) ? r - 2 : 0;
            for (k = 0; k < 3; k++)
            begin
                lft[k] = (w >= 2) ? taps[0][k] : '0;
                cen[k] = taps[1][k];
                rgt[k] = '0;
            end
        end
        else
        begin
            mc = c - 1;
            mr = (r >= 1) ? r - 1 : 0;
            for (k = 0; k < 3; k++)
            begin
                lft[k] = (c >= 2) ? taps[0][k] : '0;
                cen[k] = taps[1][k];
                rgt[k] = taps[2][k];
            end
        end
        if (r >= h + 1)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        else if (c + 1 >= w)
        begin
            pos_col = 0;
            pos_row = r + 1;
        end
        else
            pos_col = c + 1;
        gx = (int'(rgt[0]) + 2 * int'(rgt[1]) + int'(rgt[2]))
           - (int'(lft[0]) + 2 * int'(lft[1]) + int'(lft[2]));
        gy = (int'(lft[2]) + 2 * int'(cen[2]) + int'(rgt[2]))
           - (int'(lft[0]) + 2 * int'(cen[0]) + int'(rgt[0]));
        s = sat_abs(gx) + sat_abs(gy);
        if (s > 255)
            s = 255;
        res.magnitude    = 8'(s);
        res.end_of_row   = (mc == w - 1);
        res.end_of_frame = (mc == w - 1) && (mr == h - 1);
    endfunction

    function automatic logic [sem_pkg::PIXEL_W-1:0] fill_px(input fill_t fill, input int r,
                                                            input int c);
        case (fill)
            FILL_WHITE:   return sem_pkg::PIXEL_MAX;
            FILL_BLACK:   return '0;
            FILL_CHECKER: return ((r + c) % 2 == 1) ? sem_pkg::PIXEL_MAX : '0;
            FILL_STRIPES: return (c % 2 == 1) ? sem_pkg::PIXEL_MAX : '0;
            default:      return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at result %0d", what, got, want, results_seen);
        err_count++;
    endtask

    task automatic write_reg(input sem_pkg::cfg_reg_t idx,
                             input logic [sem_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sem_pkg::CFG_FRAME_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        pos_col = 0;
        pos_row = 0;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic send_beat(input sem_pkg::req_kind_t kind,
                             input logic [sem_pkg::PIXEL_W-1:0] px);
        sem_pkg::pix_beat_t b;
        sem_pkg::mag_beat_t res;
        bit                 emits;
        int                 r;
        int                 gap;
        b.req_type = kind;
        b.pixel    = px;
        pix_data  <= b;
        pix_valid <= 1'b1;
        src_held   = 1'b1;
        do
            @(posedge clk);
        while (!pix_ready);
        sobel_predict(b, emits, res);
        if (emits)
            expected_mag.push_back(res);
        beats_sent++;
        if (src_idles)
        begin
            r = $urandom_range(0, 99);
            gap = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            if (gap > 0)
            begin
                pix_valid <= 1'b0;
                src_held   = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // drop valid, wait for every expected beat, then let the pipeline empty
    task automatic settle();
        if (src_held)
        begin
            pix_valid <= 1'b0;
            src_held   = 1'b0;
        end
        while (expected_mag.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        settle();
        write_reg(sem_pkg::CFG_FRAME_WIDTH, sem_pkg::CFG_DATA_W'(w));
        write_reg(sem_pkg::CFG_FRAME_HEIGHT, sem_pkg::CFG_DATA_W'(h));
    endtask

    // one full frame from the current position: image beats, then width+1 drain beats
    task automatic send_frame(input fill_t fill);
        int w, h;
        w = frame_cols();
        h = frame_rows();
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_beat(sem_pkg::REQ_PIXEL, fill_px(fill, r, c));
        for (int i = 0; i <= w; i++)
            send_beat(sem_pkg::REQ_DRAIN, 8'($urandom));
    endtask

    task automatic test_directed();
        src_idles  = 1'b1;
        sink_idles = 1'b1;
        set_frame(3, 3);
        send_frame(FILL_CHECKER);
        // zero sizes act as a single pixel
        set_frame(0, 0);
        send_frame(FILL_WHITE);
        set_frame(2, 1);
        send_frame(FILL_STRIPES);
        settle();
    endtask

    // beat kind disagrees with frame position: a pixel counts only if both say pixel
    task automatic test_kind_mismatch();
        set_frame(4, 3);
        for (int i = 0; i < 12; i++)
            send_beat(($urandom_range(0, 2) == 0) ? sem_pkg::REQ_DRAIN : sem_pkg::REQ_PIXEL,
                      8'($urandom));
        for (int i = 0; i < 5; i++)
            send_beat(sem_pkg::REQ_PIXEL, 8'($urandom));
        settle();
    endtask

    // partial frame, rewind by a register write, then back-to-back frames over stale lines
    task automatic test_rewind();
        set_frame(5, 4);
        for (int i = 0; i < 13; i++)
            send_beat(sem_pkg::REQ_PIXEL, 8'($urandom));
        settle();
        write_reg(sem_pkg::CFG_FRAME_HEIGHT, sem_pkg::CFG_DATA_W'(4));
        send_frame(FILL_WHITE);
        send_frame(FILL_RANDOM);
        send_frame(FILL_BLACK);
        settle();
    endtask

    // single column, single row and wide-and-flat frames
    task automatic test_size_extremes();
        int ext_w [4] = '{1, 1, 37, 40};
        int ext_h [4] = '{1, 7, 1, 3};
        for (int i = 0; i < 4; i++)
        begin
            set_frame(ext_w[i], ext_h[i]);
            send_frame(FILL_RANDOM);
        end
        settle();
    endtask

    task automatic test_backpressure();
        set_frame(8, 6);
        src_idles    = 1'b0;
        sink_idles   = 1'b0;
        hold_off_len = 300;
        send_frame(FILL_RANDOM);
        send_frame(FILL_CHECKER);
        settle();
        src_idles  = 1'b1;
        sink_idles = 1'b1;
    endtask

    task automatic test_random();
        int start, r, w, h, n;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            src_idles  = ($urandom_range(0, 3) != 0);
            sink_idles = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                w = $urandom_range(0, 99);
                w = (w < 5) ? 0 : (w < 75) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                h = $urandom_range(0, 19);
                h = (h == 0) ? 0 : $urandom_range(1, 8);
                settle();
                case ($urandom_range(0, 3))
                    0:       write_reg(sem_pkg::CFG_FRAME_WIDTH, sem_pkg::CFG_DATA_W'(w));
                    1:       write_reg(sem_pkg::CFG_FRAME_HEIGHT, sem_pkg::CFG_DATA_W'(h));
                    default:
                    begin
                        write_reg(sem_pkg::CFG_FRAME_HEIGHT, sem_pkg::CFG_DATA_W'(h));
                        write_reg(sem_pkg::CFG_FRAME_WIDTH, sem_pkg::CFG_DATA_W'(w));
                    end
                endcase
            end
            else if (r < 85)
                send_frame(fill_t'($urandom_range(0, 4)));
            else
            begin
                // noise: random kinds from wherever the position stands
                n = $urandom_range(1, 2 * frame_cols() + 2);
                for (int i = 0; i < n; i++)
                    send_beat(sem_pkg::req_kind_t'($urandom_range(0, 1)), 8'($urandom));
            end
        end
        settle();
    endtask

    // result checker
    always @(posedge clk)
    begin : check_beat
        sem_pkg::mag_beat_t want;
        if (rst_n && mag_valid && mag_ready)
        begin
            if (expected_mag.size() == 0)
                report_mismatch("result with nothing pending, magnitude",
                                int'(mag_data.magnitude), -1);
            else
            begin
                want = expected_mag.pop_front();
                if (mag_data.magnitude !== want.magnitude)
                    report_mismatch("magnitude", int'(mag_data.magnitude),
                                    int'(want.magnitude));
                if (mag_data.end_of_row !== want.end_of_row)
                    report_mismatch("end_of_row", int'(mag_data.end_of_row),
                                    int'(want.end_of_row));
                if (mag_data.end_of_frame !== want.end_of_frame)
                    report_mismatch("end_of_frame", int'(mag_data.end_of_frame),
                                    int'(want.end_of_frame));
            end
            results_seen++;
        end
    end

    // receiver: always ready, random ready, or a long hold-off on request
    initial
    begin : mag_sink
        int r;
        int n;
        mag_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off_len > 0)
            begin
                n = hold_off_len;
                hold_off_len = 0;
                mag_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (!sink_idles)
            begin
                mag_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    mag_ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    mag_ready <= 1'b0;
                    n = (r < 96) ? $urandom_range(1, 3) : $urandom_range(10, 50);
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pix_valid && pix_ready) || (mag_valid && mag_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                 idle, expected_mag.size());
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : run
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = sem_pkg::CFG_FRAME_WIDTH;
        cfg_wdata  = '0;
        pix_valid  = 1'b0;
        pix_data   = '0;
        cfg_width  = sem_pkg::CFG_DATA_W'(1024);
        cfg_height = sem_pkg::CFG_DATA_W'(1024);
        pos_col    = 0;
        pos_row    = 0;
        for (int i = 0; i < MAXW; i++)
        begin
            prev2_line[i] = '0;
            prev1_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                taps[i][k] = '0;
        err_count    = 0;
        beats_sent   = 0;
        results_seen = 0;
        reg_writes   = 0;
        src_idles    = 1'b1;
        sink_idles   = 1'b1;
        src_held     = 1'b0;
        hold_off_len = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_kind_mismatch();
        test_rewind();
        test_size_extremes();
        test_backpressure();
        test_random();
        settle();

        if (expected_mag.size() != 0)
            report_mismatch("results never delivered", 0, expected_mag.size());
        $display("summary: %0d input beats, %0d results checked, %0d register writes",
                 beats_sent, results_seen, reg_writes);
        $display("summary: zero sizes, frames from 1x1 up to 40 columns, drain/kind mix, stalls");
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
